/* design/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent true at a clock edge implies consequent at the same edge.
`define FBPA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbpa: implication check failed");

// Expression must never be true at a clock edge.
`define FBPA_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("fbpa: forbidden condition seen");

`endif

/* design/fbpa_pkg.sv */
// Shared types and constants of the fixed block pool allocator.
// No dependencies; imported by every allocator module.
package fbpa_pkg;

   // defaults for the top-level parameters
   localparam int DEF_MAX_BLOCKS   = 64;
   localparam int DEF_ADDR_BITS    = 32;
   localparam int DEF_HEADER_BYTES = 16;

   // fixed register and field widths
   localparam int PAYLOAD_BITS     = 16;
   localparam int ALIGN_BITS       = 4;
   localparam int BLOCK_COUNT_BITS = 7;
   localparam int STRIDE_BITS      = 18;
   localparam int STATUS_BITS      = 2;
   localparam int CSR_INDEX_BITS   = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIRST_ADDR   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAYLOAD_SIZE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALIGN_LOG2   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BLOCK_COUNT  = 2'd3;

   // register reset values
   localparam logic [PAYLOAD_BITS-1:0]     RST_PAYLOAD_SIZE = 16'd64;
   localparam logic [ALIGN_BITS-1:0]       RST_ALIGN_LOG2   = 4'd3;
   localparam logic [BLOCK_COUNT_BITS-1:0] RST_BLOCK_COUNT  = 7'd64;

   // result status codes
   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_POOL_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NONE_USED = 2'd2;

   // request operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // shift control for the freed-block stack
   typedef struct packed {
      logic push;
      logic pop;
   } stk_ctl_type;

endpackage

/* design/fbpa_cell.sv */
// One entry of the freed-block stack: a header address register.
// Depends on fbpa_pkg for the stack control struct.
module fbpa_cell import fbpa_pkg::*; #(
   parameter int ADDR_BITS = DEF_ADDR_BITS
) (
   input  logic                 clock,
   input  stk_ctl_type          ctl,
   input  logic [ADDR_BITS-1:0] above_data,
   input  logic [ADDR_BITS-1:0] below_data,
   output logic [ADDR_BITS-1:0] data
);

   logic [ADDR_BITS-1:0] data_ff;

   // take from above on push, from below on pop, else hold
   always_ff @(posedge clock) begin
      priority if (ctl.push) begin
         data_ff <= above_data;
      end else if (ctl.pop) begin
         data_ff <= below_data;
      end else begin
         data_ff <= data_ff;
      end
   end

   assign data = data_ff;

endmodule

/* design/fbpa_stack.sv */
// Freed-block stack built as a shifting chain of fbpa_cell entries.
// Depends on fbpa_pkg and fbpa_cell; top of stack sits in cell 0.
module fbpa_stack import fbpa_pkg::*; #(
   parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
   parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
   input  logic                 clock,
   input  stk_ctl_type          ctl,
   input  logic [ADDR_BITS-1:0] push_data,
   output logic [ADDR_BITS-1:0] top_data
);

   logic [ADDR_BITS-1:0] cell_data [MAX_BLOCKS];

   // chain the cells: push shifts toward the bottom, pop toward the top
   for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
      logic [ADDR_BITS-1:0] above;
      logic [ADDR_BITS-1:0] below;

      if (i == 0) begin : g_head
         assign above = push_data;
      end else begin : g_mid
         assign above = cell_data[i-1];
      end

      if (i == MAX_BLOCKS - 1) begin : g_tail
         assign below = cell_data[i];
      end else begin : g_body
         assign below = cell_data[i+1];
      end

      fbpa_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .above_data(above),
         .below_data(below),
         .data      (cell_data[i])
      );
   end

   assign top_data = cell_data[0];

endmodule

/* design/fixed_block_pool_allocator_unit.sv */
// Fixed block pool allocator: control, counters, restart sequencer and result register.
// Depends on fbpa_pkg, fbpa_stack and assert_macros.svh.
//
// Usage:
//   req channel (req_valid/req_ready) carries one item: op 0 allocates a block,
//   op 1 frees the block whose payload address is given. rsp channel
//   (rsp_valid/rsp_ready) returns one item per request: status, granted payload
//   address, and the used and free block counts after the request.
//   rsp_valid rises in the cycle after accept. One item is accepted per cycle when
//   no restart runs and the result register is free or being taken; the freed stack
//   is a chain of cells that shifts by one entry per item, so push and pop are each a single shift.
//   The result sits in an output register: a stalled receiver holds the result,
//   and a new item is accepted in the same cycle the held one is taken.
//   After reset, and after any csr write, a restart sequence recomputes the
//   stride and the highest fresh header (stride, multiply, add); req_ready is
//   low meanwhile. Counts clear and the pool refills with block_count blocks
//   (clamped to MAX_BLOCKS). Freeing while nothing is in use returns a status
//   and changes nothing; other bad addresses are not checked.
`include "assert_macros.svh"
module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
   parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
   parameter int ADDR_BITS    = DEF_ADDR_BITS,
   parameter int HEADER_BYTES = DEF_HEADER_BYTES,
   parameter int CNT_BITS     = $clog2(MAX_BLOCKS + 1),
   parameter int CSR_BITS     = (ADDR_BITS > PAYLOAD_BITS) ? ADDR_BITS : PAYLOAD_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]       csr_write_data,
   // requests
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic [ADDR_BITS-1:0]      req_payload_address,
   // results
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_BITS-1:0]    rsp_status,
   output logic [ADDR_BITS-1:0]      rsp_granted_address,
   output logic [CNT_BITS-1:0]       rsp_used_count,
   output logic [CNT_BITS-1:0]       rsp_free_count
);

   localparam int PROD_BITS = CNT_BITS + STRIDE_BITS;
   localparam int WIDE_BITS = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS;
   localparam logic [ADDR_BITS-1:0] HDR_OFS = ADDR_BITS'(HEADER_BYTES + 1);
   localparam logic [STRIDE_BITS-1:0] RAW_OFS = STRIDE_BITS'(HEADER_BYTES + 2);

   // restart sequencer codes
   localparam logic [1:0] RS_IDLE   = 2'd0;
   localparam logic [1:0] RS_STRIDE = 2'd1;
   localparam logic [1:0] RS_MULT   = 2'd2;
   localparam logic [1:0] RS_ADD    = 2'd3;

   // configuration registers
   logic [ADDR_BITS-1:0]        first_addr_ff;
   logic [PAYLOAD_BITS-1:0]     payload_size_ff;
   logic [ALIGN_BITS-1:0]       align_log2_ff;
   logic [BLOCK_COUNT_BITS-1:0] block_count_ff;

   // restart pipeline
   logic [1:0]                  rs_ff, rs_in;
   logic [STRIDE_BITS-1:0]      stride_ff, stride_in;
   logic [CNT_BITS-1:0]         pool_ff, pool_in;
   logic [ADDR_BITS-1:0]        prod_ff;
   logic [WIDE_BITS-1:0]        prod_wide;
   logic [CNT_BITS-1:0]         pool_m1;
   logic [STRIDE_BITS-1:0]      align_mask;
   logic [STRIDE_BITS-1:0]      raw_stride;

   // pool state
   logic [CNT_BITS-1:0]         depth_ff, depth_in;
   logic [CNT_BITS-1:0]         fresh_ff, fresh_in;
   logic [CNT_BITS-1:0]         used_ff, used_in;
   logic [ADDR_BITS-1:0]        next_hdr_ff, next_hdr_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0]      status_ff, status_in;
   logic [ADDR_BITS-1:0]        granted_ff, granted_in;

   // stack interface
   stk_ctl_type                 stk_ctl;
   logic [ADDR_BITS-1:0]        stk_top;
   logic [ADDR_BITS-1:0]        free_hdr;

   logic                        req_fire;
   logic [CNT_BITS+1:0]         count_sum;
   logic                        pool_settled;
   logic                        counts_match;
   logic                        rsp_failed;

   assign req_ready = (rs_ff == RS_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign free_hdr  = req_payload_address - HDR_OFS;

   // stride: header + payload + two guards, rounded up to the alignment
   assign align_mask = ~((STRIDE_BITS'(1) << align_log2_ff) - STRIDE_BITS'(1));
   assign raw_stride = STRIDE_BITS'(payload_size_ff) + RAW_OFS;
   assign stride_in  = (raw_stride + ~align_mask) & align_mask;
   assign pool_in    = (int'(block_count_ff) > MAX_BLOCKS) ? CNT_BITS'(MAX_BLOCKS)
                                                           : CNT_BITS'(block_count_ff);
   assign pool_m1    = (pool_ff == '0) ? '0 : pool_ff - CNT_BITS'(1);
   assign prod_wide  = WIDE_BITS'(pool_m1) * WIDE_BITS'(stride_ff);

   // step the restart sequence
   always_comb begin
      rs_in = rs_ff;
      unique case (rs_ff)
         RS_IDLE:   rs_in = RS_IDLE;
         RS_STRIDE: rs_in = RS_MULT;
         RS_MULT:   rs_in = RS_ADD;
         RS_ADD:    rs_in = RS_IDLE;
         default:   rs_in = RS_IDLE;
      endcase
      if (csr_write_enable) begin
         rs_in = RS_STRIDE;
      end
   end

   // decide the item: pop, take fresh, push, or report a status
   always_comb begin
      depth_in     = depth_ff;
      fresh_in     = fresh_ff;
      used_in      = used_ff;
      next_hdr_in  = next_hdr_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      stk_ctl      = '0;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         granted_in   = '0;
         unique case (req_op)
            OP_ALLOC: begin
               priority if (depth_ff != '0) begin
                  granted_in  = stk_top + HDR_OFS;
                  depth_in    = depth_ff - CNT_BITS'(1);
                  used_in     = used_ff + CNT_BITS'(1);
                  stk_ctl.pop = 1'b1;
               end else if (fresh_ff != '0) begin
                  granted_in  = next_hdr_ff + HDR_OFS;
                  next_hdr_in = next_hdr_ff - ADDR_BITS'(stride_ff);
                  fresh_in    = fresh_ff - CNT_BITS'(1);
                  used_in     = used_ff + CNT_BITS'(1);
               end else begin
                  status_in = ST_POOL_EMPTY;
               end
            end
            OP_FREE: begin
               if (used_ff == '0) begin
                  status_in = ST_NONE_USED;
               end else begin
                  depth_in     = depth_ff + CNT_BITS'(1);
                  used_in      = used_ff - CNT_BITS'(1);
                  stk_ctl.push = 1'b1;
               end
            end
            default: status_in = ST_OK;
         endcase
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_addr_ff   <= '0;
         payload_size_ff <= RST_PAYLOAD_SIZE;
         align_log2_ff   <= RST_ALIGN_LOG2;
         block_count_ff  <= RST_BLOCK_COUNT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FIRST_ADDR:   first_addr_ff   <= csr_write_data[ADDR_BITS-1:0];
            CSR_PAYLOAD_SIZE: payload_size_ff <= csr_write_data[PAYLOAD_BITS-1:0];
            CSR_ALIGN_LOG2:   align_log2_ff   <= csr_write_data[ALIGN_BITS-1:0];
            CSR_BLOCK_COUNT:  block_count_ff  <= csr_write_data[BLOCK_COUNT_BITS-1:0];
            default:          first_addr_ff   <= first_addr_ff;
         endcase
      end
   end

   // control state: restart on reset or write, else advance the item
   always_ff @(posedge clock) begin
      if (reset) begin
         rs_ff        <= RS_STRIDE;
         depth_ff     <= '0;
         fresh_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (csr_write_enable) begin
         rs_ff        <= rs_in;
         depth_ff     <= '0;
         fresh_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= rsp_valid_in;
      end else begin
         rs_ff        <= rs_in;
         depth_ff     <= depth_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         fresh_ff     <= (rs_ff == RS_STRIDE) ? pool_in : fresh_in;
      end
   end

   // restart datapath and result payload
   always_ff @(posedge clock) begin
      if (rs_ff == RS_STRIDE) begin
         stride_ff <= stride_in;
         pool_ff   <= pool_in;
      end
      if (rs_ff == RS_MULT) begin
         prod_ff <= prod_wide[ADDR_BITS-1:0];
      end
      if (rs_ff == RS_ADD) begin
         next_hdr_ff <= first_addr_ff + prod_ff;
      end else begin
         next_hdr_ff <= next_hdr_in;
      end
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   fbpa_stack #(
      .MAX_BLOCKS(MAX_BLOCKS),
      .ADDR_BITS (ADDR_BITS)
   ) u_stack (
      .clock    (clock),
      .ctl      (stk_ctl),
      .push_data(free_hdr),
      .top_data (stk_top)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_granted_address = granted_ff;
   assign rsp_used_count      = used_ff;
   assign rsp_free_count      = depth_ff + fresh_ff;

   assign count_sum = (CNT_BITS+2)'(used_ff) + (CNT_BITS+2)'(depth_ff)
                    + (CNT_BITS+2)'(fresh_ff);
   assign pool_settled = (rs_ff == RS_IDLE) && !csr_write_enable;
   assign counts_match = (count_sum == (CNT_BITS+2)'(pool_ff));
   assign rsp_failed   = rsp_valid && (rsp_status != ST_OK);

   // every pool block is either in use, freed, or fresh once restart is done
   `FBPA_ASSERT_IMPLIES(a_block_conservation, clock, reset, pool_settled, counts_match)
   // no item is taken while the pool restarts
   `FBPA_ASSERT_IMPLIES(a_no_accept_in_restart, clock, reset, (rs_ff != RS_IDLE), !req_ready)
   // a failed item never grants an address
   `FBPA_ASSERT_IMPLIES(a_fail_no_grant, clock, reset, rsp_failed, (rsp_granted_address == '0))
   // stack never shifts both ways at once
   `FBPA_ASSERT_NEVER(a_stack_ctl_excl, clock, reset, (stk_ctl.push && stk_ctl.pop))

endmodule
